@@ rtl/core/vbw_pkg.sv @@
// ----------------------------------------------------------------------------
// vbw_pkg: shared types and constants of the volume block walker
// Register map, tile shapes and sequencer states.
// ----------------------------------------------------------------------------
package vbw_pkg;

	// Width of the block-size register and of the configuration data bus
	localparam int MB_W      = 37;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DIM_Z     = 2'd0,
		REG_DIM_Y     = 2'd1,
		REG_DIM_X     = 2'd2,
		REG_MAX_BLOCK = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MODE_SLAB  = 2'd0,
		MODE_ROW   = 2'd1,
		MODE_PIECE = 2'd2
	} tile_mode_t;

	typedef enum logic [5:0] {
		ST_IDLE      = 6'b000001,
		ST_START     = 6'b000010,
		ST_DIV_PLANE = 6'b000100,
		ST_DIV_ROW   = 6'b001000,
		ST_SETUP     = 6'b010000,
		ST_EMIT      = 6'b100000
	} seq_state_t;

endpackage

@@ rtl/core/vbw_if.sv @@
// ----------------------------------------------------------------------------
// vbw_if: request and block channels of the volume block walker
// Valid/ready channels; a transaction moves at a clock edge with both high.
// ----------------------------------------------------------------------------
interface vbw_req_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink   (input valid, input restart, output ready);
endinterface

interface vbw_blk_if #(parameter int DIM_BITS = 12);
	logic                valid;
	logic                ready;
	logic [DIM_BITS-1:0] z_offset;
	logic [DIM_BITS-1:0] y_offset;
	logic [DIM_BITS-1:0] x_offset;
	logic [DIM_BITS:0]   z_count;
	logic [DIM_BITS:0]   y_count;
	logic [DIM_BITS:0]   x_count;
	logic                last_block;

	modport source (output valid, output z_offset, output y_offset, output x_offset,
		output z_count, output y_count, output x_count, output last_block, input ready);
	modport sink   (input valid, input z_offset, input y_offset, input x_offset,
		input z_count, input y_count, input x_count, input last_block, output ready);
endinterface

@@ rtl/core/vbw_div.sv @@
// ----------------------------------------------------------------------------
// vbw_div: radix-2 restoring divider
// One quotient bit per cycle; operands are latched at start.
// ----------------------------------------------------------------------------
module vbw_div #(
	parameter int DVD_W = 37,
	parameter int DVS_W = 25
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quot,
	output logic [DVS_W-1:0] rem
);
	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0] dvd_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             fits;

	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Quotient bits shift into the dividend register from the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = dvd_q;
	assign rem  = rem_q;

endmodule

@@ rtl/core/volume_block_walker.sv @@
// ----------------------------------------------------------------------------
// volume_block_walker: 3D volume block address generator
// Walks a z/y/x volume in blocks of at most max_block elements.
// ----------------------------------------------------------------------------
// Each request transaction returns one block: its start offsets, its counts
// along z, y and x, and a last_block flag on the block that completes the
// volume. A steady request is accepted, then advances the walk and loads the
// output register once it is empty or draining; the output register lets the
// next request be taken while a block still waits downstream. A request that
// opens a walk (restart high, or the previous walk finished, or the first
// request after reset) first sizes the blocks with the shared 37-bit
// restoring divider: one multiply of dim_y by dim_x, then max_block / plane,
// and, when not even one whole slab fits, a second pass that splits the
// remainder by dim_x. Dimension registers of zero act as one, and values
// above 2^DIM_BITS act as 2^DIM_BITS; a max_block of zero acts as one. Write
// the configuration only while no request is in flight.
// ----------------------------------------------------------------------------
module volume_block_walker #(
	parameter int DIM_BITS = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [vbw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [vbw_pkg::MB_W-1:0]      cfg_data,
	vbw_req_if.sink                       req,
	vbw_blk_if.source                     blk
);
	import vbw_pkg::*;

	localparam int CNT_W   = DIM_BITS + 1;
	localparam int SUM_W   = DIM_BITS + 2;
	localparam int PLANE_W = 2 * DIM_BITS + 1;
	localparam int PROD_W  = 2 * CNT_W;
	localparam logic [CNT_W-1:0] DIM_MAX = {1'b1, {DIM_BITS{1'b0}}};

	// Clamp a dimension register into 1 .. 2^DIM_BITS
	function automatic logic [CNT_W-1:0] live_dim(input logic [CNT_W-1:0] v);
		if (v == '0) begin
			return CNT_W'(1);
		end else if (v > DIM_MAX) begin
			return DIM_MAX;
		end
		return v;
	endfunction

	// Configuration registers
	logic [CNT_W-1:0] dim_z_q, dim_y_q, dim_x_q;
	logic [MB_W-1:0]  max_block_q;

	// Sequencer and walk state
	seq_state_t       state_q, state_d;
	logic             active_q;
	tile_mode_t       mode_q;
	logic [CNT_W-1:0] slab_chunk_q, row_chunk_q, col_chunk_q;
	logic [DIM_BITS-1:0] cur_z_q, cur_y_q, cur_x_q;
	logic [CNT_W-1:0]    cnt_z_q, cnt_y_q, cnt_x_q;

	// Output register
	logic                o_valid_q;
	logic [DIM_BITS-1:0] o_z_off_q, o_y_off_q, o_x_off_q;
	logic [CNT_W-1:0]    o_z_cnt_q, o_y_cnt_q, o_x_cnt_q;
	logic                o_last_q;

	// Live extents and block size
	logic [CNT_W-1:0]   dz, dy, dx;
	logic [MB_W-1:0]    mb;
	logic [PROD_W-1:0]  plane_full;
	logic [PLANE_W-1:0] plane;

	// Divider hookup
	logic               div_start;
	logic [MB_W-1:0]    div_dvd;
	logic [PLANE_W-1:0] div_dvs;
	logic               div_done;
	logic [MB_W-1:0]    div_quot;
	logic [PLANE_W-1:0] div_rem;
	logic [CNT_W-1:0]   slab_next;

	// Advance of the walk
	logic [SUM_W-1:0]    sum_z, sum_y, sum_x;
	logic [CNT_W-1:0]    inc_z, inc_y;
	logic [DIM_BITS-1:0] nxt_cur_z, nxt_cur_y, nxt_cur_x;
	logic [CNT_W-1:0]    nxt_cnt_z, nxt_cnt_y, nxt_cnt_x;
	logic                adv_done;
	logic                emit_ok;

	assign dz = live_dim(dim_z_q);
	assign dy = live_dim(dim_y_q);
	assign dx = live_dim(dim_x_q);
	assign mb = (max_block_q == '0) ? MB_W'(1) : max_block_q;

	// Plane size never exceeds 2^(2*DIM_BITS); the divider latches it
	assign plane_full = PROD_W'(dy) * PROD_W'(dx);
	assign plane      = plane_full[PLANE_W-1:0];

	// A block may be loaded when the output register is empty or draining
	assign emit_ok = !o_valid_q || blk.ready;

	vbw_div #(
		.DVD_W (MB_W),
		.DVS_W (PLANE_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_z_q     <= CNT_W'(1);
			dim_y_q     <= CNT_W'(1);
			dim_x_q     <= CNT_W'(1);
			max_block_q <= MB_W'(1);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_DIM_Z:     dim_z_q     <= cfg_data[CNT_W-1:0];
				REG_DIM_Y:     dim_y_q     <= cfg_data[CNT_W-1:0];
				REG_DIM_X:     dim_x_q     <= cfg_data[CNT_W-1:0];
				REG_MAX_BLOCK: max_block_q <= cfg_data;
				default:       max_block_q <= max_block_q;
			endcase
		end
	end

	// Sequencer: a walk start runs plane division, then, if no whole slab
	// fits, the row division; every request ends in the emit step.
	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		div_dvd   = MB_W'(div_rem);
		div_dvs   = PLANE_W'(dx);
		slab_next = (div_quot < MB_W'(dz)) ? div_quot[CNT_W-1:0] : dz;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					state_d = (req.restart || !active_q) ? ST_START : ST_EMIT;
				end
			end
			ST_START: begin
				div_start = 1'b1;
				div_dvd   = mb;
				div_dvs   = plane;
				state_d   = ST_DIV_PLANE;
			end
			ST_DIV_PLANE: begin
				if (div_done) begin
					if (slab_next != '0) begin
						state_d = ST_SETUP;
					end else begin
						// split the remainder of the plane division into rows
						div_start = 1'b1;
						state_d   = ST_DIV_ROW;
					end
				end
			end
			ST_DIV_ROW: begin
				if (div_done) begin
					state_d = ST_SETUP;
				end
			end
			ST_SETUP: state_d = ST_EMIT;
			ST_EMIT: begin
				if (emit_ok) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Step the walk along the tiled axis, carrying into the slower axes
	// and clipping the count at the far edge.
	always_comb begin
		sum_z     = SUM_W'(cur_z_q) + SUM_W'(cnt_z_q);
		sum_y     = SUM_W'(cur_y_q) + SUM_W'(cnt_y_q);
		sum_x     = SUM_W'(cur_x_q) + SUM_W'(cnt_x_q);
		inc_z     = CNT_W'(cur_z_q) + CNT_W'(1);
		inc_y     = CNT_W'(cur_y_q) + CNT_W'(1);
		nxt_cur_z = cur_z_q;
		nxt_cur_y = cur_y_q;
		nxt_cur_x = cur_x_q;
		nxt_cnt_z = cnt_z_q;
		nxt_cnt_y = cnt_y_q;
		nxt_cnt_x = cnt_x_q;
		adv_done  = 1'b0;
		case (mode_q)
			MODE_SLAB: begin
				if (sum_z >= SUM_W'(dz)) begin
					adv_done = 1'b1;
				end else begin
					nxt_cur_z = sum_z[DIM_BITS-1:0];
					if (sum_z + SUM_W'(cnt_z_q) >= SUM_W'(dz)) begin
						nxt_cnt_z = dz - sum_z[CNT_W-1:0];
					end
				end
			end
			MODE_ROW: begin
				if (sum_y >= SUM_W'(dy)) begin
					if (inc_z >= dz) begin
						adv_done = 1'b1;
					end else begin
						nxt_cur_z = inc_z[DIM_BITS-1:0];
						nxt_cur_y = '0;
						nxt_cnt_y = row_chunk_q;
					end
				end else begin
					nxt_cur_y = sum_y[DIM_BITS-1:0];
					if (sum_y + SUM_W'(cnt_y_q) >= SUM_W'(dy)) begin
						nxt_cnt_y = dy - sum_y[CNT_W-1:0];
					end
				end
			end
			default: begin
				// row pieces; the unused mode code behaves the same way
				if (sum_x >= SUM_W'(dx)) begin
					if (inc_y >= dy) begin
						if (inc_z >= dz) begin
							adv_done = 1'b1;
						end else begin
							nxt_cur_z = inc_z[DIM_BITS-1:0];
							nxt_cur_y = '0;
							nxt_cur_x = '0;
							nxt_cnt_x = col_chunk_q;
						end
					end else begin
						nxt_cur_y = inc_y[DIM_BITS-1:0];
						nxt_cur_x = '0;
						nxt_cnt_x = col_chunk_q;
					end
				end else begin
					nxt_cur_x = sum_x[DIM_BITS-1:0];
					if (sum_x + SUM_W'(cnt_x_q) >= SUM_W'(dx)) begin
						nxt_cnt_x = dx - sum_x[CNT_W-1:0];
					end
				end
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			active_q  <= 1'b0;
			o_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_SETUP) begin
				active_q <= 1'b1;
			end else if (state_q == ST_EMIT && emit_ok && adv_done) begin
				// the next request opens a new walk
				active_q <= 1'b0;
			end
			if (state_q == ST_EMIT && emit_ok) begin
				o_valid_q <= 1'b1;
			end else if (blk.ready) begin
				o_valid_q <= 1'b0;
			end
		end
	end

	// Walk geometry and output payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_DIV_PLANE: begin
				if (div_done) begin
					slab_chunk_q <= slab_next;
				end
			end
			ST_DIV_ROW: begin
				if (div_done) begin
					row_chunk_q <= div_quot[CNT_W-1:0];
					col_chunk_q <= div_rem[CNT_W-1:0];
				end
			end
			ST_SETUP: begin
				cur_z_q <= '0;
				cur_y_q <= '0;
				cur_x_q <= '0;
				if (slab_chunk_q != '0) begin
					mode_q  <= MODE_SLAB;
					cnt_z_q <= slab_chunk_q;
					cnt_y_q <= dy;
					cnt_x_q <= dx;
				end else if (row_chunk_q != '0) begin
					mode_q  <= MODE_ROW;
					cnt_z_q <= CNT_W'(1);
					cnt_y_q <= row_chunk_q;
					cnt_x_q <= dx;
				end else begin
					mode_q  <= MODE_PIECE;
					cnt_z_q <= CNT_W'(1);
					cnt_y_q <= CNT_W'(1);
					cnt_x_q <= col_chunk_q;
				end
			end
			ST_EMIT: begin
				if (emit_ok) begin
					o_z_off_q <= cur_z_q;
					o_y_off_q <= cur_y_q;
					o_x_off_q <= cur_x_q;
					o_z_cnt_q <= cnt_z_q;
					o_y_cnt_q <= cnt_y_q;
					o_x_cnt_q <= cnt_x_q;
					o_last_q  <= adv_done;
					cur_z_q   <= nxt_cur_z;
					cur_y_q   <= nxt_cur_y;
					cur_x_q   <= nxt_cur_x;
					cnt_z_q   <= nxt_cnt_z;
					cnt_y_q   <= nxt_cnt_y;
					cnt_x_q   <= nxt_cnt_x;
				end
			end
			default: ;
		endcase
	end

	// Requests are taken only between walk steps
	assign req.ready = (state_q == ST_IDLE);

	assign blk.valid      = o_valid_q;
	assign blk.z_offset   = o_z_off_q;
	assign blk.y_offset   = o_y_off_q;
	assign blk.x_offset   = o_x_off_q;
	assign blk.z_count    = o_z_cnt_q;
	assign blk.y_count    = o_y_cnt_q;
	assign blk.x_count    = o_x_cnt_q;
	assign blk.last_block = o_last_q;

endmodule

@@ rtl/core/vbw_chk.sv @@
// ----------------------------------------------------------------------------
// vbw_chk: port-level checks of the volume block walker
// Watches the request and block channels; bound to the top level.
// ----------------------------------------------------------------------------
module vbw_chk #(
	parameter int DIM_BITS = 12
) (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input logic                blk_valid,
	input logic                blk_ready,
	input logic [DIM_BITS-1:0] z_offset,
	input logic [DIM_BITS-1:0] y_offset,
	input logic [DIM_BITS-1:0] x_offset,
	input logic [DIM_BITS:0]   z_count,
	input logic [DIM_BITS:0]   y_count,
	input logic [DIM_BITS:0]   x_count,
	input logic                last_block
);
	logic       in_acc, out_acc;
	logic [1:0] pend_q;
	logic       fresh_q;

	assign in_acc  = req_valid && req_ready;
	assign out_acc = blk_valid && blk_ready;

	// Requests taken minus blocks delivered; next block opens a fresh walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= '0;
			fresh_q <= 1'b1;
		end else begin
			pend_q <= pend_q + {1'b0, in_acc} - {1'b0, out_acc};
			if (out_acc) begin
				fresh_q <= last_block;
			end
		end
	end

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		blk_valid && !blk_ready |=> blk_valid && $stable(z_offset) && $stable(y_offset)
			&& $stable(x_offset) && $stable(z_count) && $stable(y_count)
			&& $stable(x_count) && $stable(last_block))
		else $error("stalled block transaction changed");

	a_no_spurious_block: assert property (@(posedge clk) disable iff (!arst_n)
		blk_valid |-> pend_q != 2'd0)
		else $error("block presented without a pending request");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> pend_q <= 2'd1)
		else $error("request taken with two blocks outstanding");

	a_walk_starts_at_origin: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && fresh_q |-> z_offset == '0 && y_offset == '0 && x_offset == '0)
		else $error("new walk does not start at the origin");

	a_counts_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		blk_valid |-> z_count != '0 && y_count != '0 && x_count != '0)
		else $error("empty block presented");

endmodule

bind volume_block_walker vbw_chk #(.DIM_BITS(DIM_BITS)) u_vbw_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.blk_valid  (blk.valid),
	.blk_ready  (blk.ready),
	.z_offset   (blk.z_offset),
	.y_offset   (blk.y_offset),
	.x_offset   (blk.x_offset),
	.z_count    (blk.z_count),
	.y_count    (blk.y_count),
	.x_count    (blk.x_count),
	.last_block (blk.last_block)
);
